[sv/tdpt_pkg.sv]
// ----------------------------------------------------------------------------
// tdpt_pkg: trial division prime test constants
// fixed divisor sequence values shared by the prime test datapath
// ----------------------------------------------------------------------------
package tdpt_pkg;

  // first odd prime tried by division (factor two is seen in the lsb)
  localparam int unsigned SMALL_DIVISOR = 3;
  // first divisor of the 6k +/- 1 sequence
  localparam int unsigned FIRST_DIVISOR = 5;
  // distance between the two divisors of a pair
  localparam int unsigned PAIR_OFFSET   = 2;
  // step from one pair to the next
  localparam int unsigned DIVISOR_STEP  = 6;

endpackage

[sv/trial_division_prime_test_unit.sv]
// ----------------------------------------------------------------------------
// trial_division_prime_test_unit: primality test by 6k +/- 1 trial division
// one shared restoring divider computes each remainder, one bit per cycle
// ----------------------------------------------------------------------------
// steps: 0..3 and even numbers go straight to the result; otherwise the
//   divide by three, then for each pair a bound check and one pass of the
//   bit-serial remainder unit per divisor tried, and then the result
// throughput: one item at a time, in_ready is low until the item is finished
// reset: synchronous active-low rst_n returns the sequencer to idle and
//   drops out_valid; no clearing pass is needed
module trial_division_prime_test_unit import tdpt_pkg::*; #(
  parameter int N_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [N_BITS-1:0] in_number,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_is_prime
);

  // divisor width: the loop stops once d * d exceeds the number,
  // so d stays below 2^(N_BITS/2) + DIVISOR_STEP
  localparam int DW  = N_BITS / 2 + 3;
  // running square width: may pass the number by one step before the stop
  localparam int SQW = N_BITS + 2;
  // bit counter for one division pass
  localparam int CW  = $clog2(N_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BOUND,
    S_DIV,
    S_TEST,
    S_RESULT
  } state_t;

  state_t            state_r, state_nxt;
  logic [N_BITS-1:0] num_r, num_nxt;       // number under test
  logic [N_BITS-1:0] work_r, work_nxt;     // dividend bits still to shift in
  logic [DW-1:0]     rem_r, rem_nxt;       // partial remainder
  logic [DW-1:0]     div_r, div_nxt;       // divisor of the current pass
  logic [DW-1:0]     d_r, d_nxt;           // base divisor of the pair (6k - 1)
  logic [SQW-1:0]    sq_r, sq_nxt;         // d_r squared, kept by increments
  logic [CW-1:0]     cnt_r, cnt_nxt;       // bits left in this pass, less one
  logic              res_r, res_nxt;       // verdict waiting for the output
  logic              out_valid_r, out_valid_nxt;
  logic              out_is_prime_r, out_is_prime_nxt;

  // shared divider step: shift in the next dividend bit, subtract if it fits
  logic [DW:0]       shifted;
  logic [DW:0]       diff;
  logic              fits;
  // square update: (d + 6)^2 = d^2 + 12 d + 36
  logic [SQW-1:0]    sq_step;

  assign shifted = {rem_r, work_r[N_BITS-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign fits    = shifted >= {1'b0, div_r};
  assign sq_step = SQW'(d_r) * SQW'(2 * DIVISOR_STEP)
                 + SQW'(DIVISOR_STEP * DIVISOR_STEP);

  assign in_ready     = (state_r == S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_is_prime_r;

  always_comb begin
    state_nxt        = state_r;
    num_nxt          = num_r;
    work_nxt         = work_r;
    rem_nxt          = rem_r;
    div_nxt          = div_r;
    d_nxt            = d_r;
    sq_nxt           = sq_r;
    cnt_nxt          = cnt_r;
    res_nxt          = res_r;
    out_valid_nxt    = out_valid_r;
    out_is_prime_nxt = out_is_prime_r;

    // result taken downstream
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          num_nxt = in_number;
          if (in_number <= N_BITS'(1)) begin
            // zero and one are not prime
            res_nxt   = 1'b0;
            state_nxt = S_RESULT;
          end else if (in_number <= N_BITS'(SMALL_DIVISOR)) begin
            // two and three are prime
            res_nxt   = 1'b1;
            state_nxt = S_RESULT;
          end else if (!in_number[0]) begin
            // even and above two
            res_nxt   = 1'b0;
            state_nxt = S_RESULT;
          end else begin
            // start with the divide by three
            d_nxt     = DW'(SMALL_DIVISOR);
            div_nxt   = DW'(SMALL_DIVISOR);
            rem_nxt   = '0;
            work_nxt  = in_number;
            cnt_nxt   = CW'(N_BITS - 1);
            state_nxt = S_DIV;
          end
        end
      end

      S_BOUND: begin
        // keep going while d * d does not exceed the number
        if (sq_r <= SQW'(num_r)) begin
          div_nxt   = d_r;
          rem_nxt   = '0;
          work_nxt  = num_r;
          cnt_nxt   = CW'(N_BITS - 1);
          state_nxt = S_DIV;
        end else begin
          res_nxt   = 1'b1;
          state_nxt = S_RESULT;
        end
      end

      S_DIV: begin
        rem_nxt  = fits ? diff[DW-1:0] : shifted[DW-1:0];
        work_nxt = work_r << 1;
        cnt_nxt  = cnt_r - CW'(1);
        if (cnt_r == '0) begin
          state_nxt = S_TEST;
        end
      end

      S_TEST: begin
        if (rem_r == '0) begin
          // divisor found
          res_nxt   = 1'b0;
          state_nxt = S_RESULT;
        end else if (d_r == DW'(SMALL_DIVISOR)) begin
          // three done, open the 6k +/- 1 sequence
          d_nxt     = DW'(FIRST_DIVISOR);
          sq_nxt    = SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
          state_nxt = S_BOUND;
        end else if (div_r == d_r) begin
          // second divisor of the pair
          div_nxt   = d_r + DW'(PAIR_OFFSET);
          rem_nxt   = '0;
          work_nxt  = num_r;
          cnt_nxt   = CW'(N_BITS - 1);
          state_nxt = S_DIV;
        end else begin
          // next pair
          d_nxt     = d_r + DW'(DIVISOR_STEP);
          sq_nxt    = sq_r + sq_step;
          state_nxt = S_BOUND;
        end
      end

      S_RESULT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_is_prime_nxt = res_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      out_is_prime_r <= 1'b0;
      res_r          <= 1'b0;
      num_r          <= '0;
      work_r         <= '0;
      rem_r          <= '0;
      div_r          <= DW'(FIRST_DIVISOR);
      d_r            <= DW'(FIRST_DIVISOR);
      sq_r           <= '0;
      cnt_r          <= '0;
    end else begin
      state_r        <= state_nxt;
      out_valid_r    <= out_valid_nxt;
      out_is_prime_r <= out_is_prime_nxt;
      res_r          <= res_nxt;
      num_r          <= num_nxt;
      work_r         <= work_nxt;
      rem_r          <= rem_nxt;
      div_r          <= div_nxt;
      d_r            <= d_nxt;
      sq_r           <= sq_nxt;
      cnt_r          <= cnt_nxt;
    end
  end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for trial_division_prime_test_unit
// drives numbers through the valid/ready input channel and compares every
// returned flag against a local 6k +/- 1 trial division predictor; the input
// and result sides idle and stall at random in phases
// ----------------------------------------------------------------------------
module tb_top import tdpt_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_BITS = 32;

  // idling phases for the two channel sides
  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [N_BITS-1:0] number;
    bit                flag;
  } prime_answer_t;

  // keeps the flags still owed by the block, oldest first
  class prime_scoreboard;
    prime_answer_t owed_answers[$];
    int            errors;
    int            results_seen;

    // 6k +/- 1 trial division, wide enough that d * d never overflows
    function bit prime_by_trial_division(logic [N_BITS-1:0] value);
      longint unsigned x;
      longint unsigned d;
      x = value;
      if (x <= 1) return 1'b0;
      if (x <= SMALL_DIVISOR) return 1'b1;
      if (x % 2 == 0 || x % SMALL_DIVISOR == 0) return 1'b0;
      for (d = FIRST_DIVISOR; d <= x / d; d += DIVISOR_STEP)
        if (x % d == 0 || x % (d + PAIR_OFFSET) == 0) return 1'b0;
      return 1'b1;
    endfunction

    function void note_number(logic [N_BITS-1:0] value);
      prime_answer_t answer;
      answer.number = value;
      answer.flag   = prime_by_trial_division(value);
      owed_answers.push_back(answer);
    endfunction

    function void check_flag(bit got);
      prime_answer_t answer;
      results_seen++;
      if (owed_answers.size() == 0) begin
        $display("%0t: unexpected result, expected none, got is_prime=%0b", $time, got);
        errors++;
        return;
      end
      answer = owed_answers.pop_front();
      if (got !== answer.flag) begin
        $display("%0t: is_prime mismatch for number %0d: expected %0b, got %0b",
                 $time, answer.number, answer.flag, got);
        errors++;
      end
    endfunction

    function int pending();
      return owed_answers.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [N_BITS-1:0] in_number;
  logic              out_valid;
  logic              out_ready;
  logic              out_is_prime;

  prime_scoreboard primes = new();
  idle_mode_t      idle_mode = IDLE_NONE;
  bit              held_off  = 1'b0;

  trial_division_prime_test_unit #(.N_BITS(N_BITS)) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_number    (in_number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_is_prime (out_is_prime)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop, well beyond the slowest passing run
  initial begin
    #25_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic bit chance(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int sender_idle_pct();
    case (idle_mode)
      IDLE_SENDER: return 46;
      IDLE_BOTH:   return 15;
      default:     return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (idle_mode)
      IDLE_RECEIVER: return 46;
      IDLE_BOTH:     return 15;
      default:       return 0;
    endcase
  endfunction

  // note every accepted item and check every accepted result at the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) primes.note_number(in_number);
    if (rst_n && out_valid && out_ready) primes.check_flag(out_is_prime);
  end

  // offer one number; called right after a falling edge, returns after one
  task automatic send_number(input logic [N_BITS-1:0] value);
    while (chance(sender_idle_pct())) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_number <= value;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // random number, mostly small so that the divisor loop stays short
  function automatic logic [N_BITS-1:0] random_number();
    int unsigned       pick;
    int unsigned       factor;
    logic [N_BITS-1:0] value;
    pick = $urandom_range(99);
    if (pick < 8) begin
      value = $urandom_range(3);
    end else if (pick < 70) begin
      value = $urandom_range(4095);
    end else if (pick < 82) begin
      value = $urandom_range(262143);
    end else if (pick < 92) begin
      // full width composite with a small factor, found in the first pairs
      case ($urandom_range(3))
        0: factor = 5;
        1: factor = 7;
        2: factor = 11;
        default: factor = 13;
      endcase
      value = factor * $urandom_range(32'hFFFF_FFFF / factor, 1);
    end else begin
      // full width, rejected by the two or three test
      value = $urandom();
      if (pick[0]) value[0] = 1'b0;
      else value = value - (value % SMALL_DIVISOR);
    end
    return value;
  endfunction

  // result side: random stalls per phase, plus one long hold-off that lets
  // the block fill up and drop in_ready while the sender keeps offering
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held_off && primes.results_seen >= 30) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      out_ready <= !chance(receiver_stall_pct());
    end
  end

  initial begin
    logic [N_BITS-1:0] directed_numbers[$];
    int                idx;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_number = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // small values, squares and twin products at the loop bound, both ends
    // of the range, and a 24-bit prime plus a prime square that run long
    directed_numbers = {0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 25, 35, 49, 121, 143, 169,
                        32'd289, 32'd323, 32'hFFFF_FFFF, 32'h8000_0000,
                        32'hFFFF_FFF5, 32'h8000_0001, 32'd16777213, 32'd16752649};
    idle_mode = IDLE_NONE;
    foreach (directed_numbers[i]) send_number(directed_numbers[i]);

    // random part, cycling through the idling phases every ten items
    for (idx = 0; idx < 76; idx++) begin
      idle_mode = idle_mode_t'((idx / 10) % 4);
      send_number(random_number());
    end
    in_valid <= 1'b0;

    while (primes.pending() != 0) @(posedge clk);
    // no result can follow the last one, only a short drain
    repeat (100) @(posedge clk);

    if (primes.errors == 0 && primes.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/tdpt_pkg.sv
sv/trial_division_prime_test_unit.sv
test/tb_top.sv
